@@ sv/dac_pkg.sv @@
package dac_pkg;

  localparam int ADDR_W   = 48;
  localparam int OUT_CNT_W = 7;

  localparam logic CMD_OBSERVE = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } dac_state_t;

  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [ADDR_W-1:0] addr;
  } dac_probe_t;

endpackage

@@ sv/dac_cell.sv @@
module dac_cell #(
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [CNT_W-1:0]        count,
  input  logic                    wr_en,
  input  logic [dac_pkg::ADDR_W-1:0] wr_addr,
  input  dac_pkg::dac_probe_t     probe_i,
  output dac_pkg::dac_probe_t     probe_o
);
  import dac_pkg::*;

  logic [ADDR_W-1:0] entry_r;
  logic              vld_r;
  logic              hit_r;
  logic              hit_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic              in_use;

  assign in_use  = count > CNT_W'(IDX);
  assign hit_nxt = probe_i.hit | (in_use && (entry_r == probe_i.addr));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= probe_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    hit_r  <= hit_nxt;
    addr_r <= probe_i.addr;
    if (wr_en && (count == CNT_W'(IDX))) begin
      entry_r <= wr_addr;
    end
  end

  assign probe_o.vld  = vld_r;
  assign probe_o.hit  = hit_r;
  assign probe_o.addr = addr_r;

endmodule

@@ sv/distinct_address_counter.sv @@
// Counts distinct 48-bit device addresses in a row of MAX_DEVICES cells,
// each holding one stored address. An observe transaction sends a probe
// down the row, one cell per cycle, each occupied cell flagging a match;
// after the probe leaves the last cell the result is loaded into the output
// register; the load waits while the previous result has not been taken.
// A clear transaction skips the walk and loads its result the same way.
// One transaction is worked on at a time; the input is ready again as soon
// as the result sits in the output register, even if it has not yet been
// taken.
module distinct_address_counter #(
  parameter int MAX_DEVICES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // device_address[47:0]
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // is_new, distinct_count[6:0], overflowed, zero pad
);
  import dac_pkg::*;

  localparam int CNT_W = $clog2(MAX_DEVICES + 1);

  dac_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              flag_r, flag_nxt;
  logic              cmd_r;
  logic              hit_r;
  logic [ADDR_W-1:0] pend_addr_r;
  logic              wr_en;
  logic              accept;
  logic              slot_free;
  logic              load_out;
  logic              is_new;
  logic              out_vld_r;
  logic [15:0]       out_data_r;
  logic [CNT_W+OUT_CNT_W-1:0] cnt_ext;

  dac_probe_t chain [MAX_DEVICES+1];

  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_vld_r || out_tready;

  assign chain[0].vld  = accept && (in_tuser == CMD_OBSERVE);
  assign chain[0].hit  = 1'b0;
  assign chain[0].addr = in_tdata;

  for (genvar i = 0; i < MAX_DEVICES; i++) begin : g_cell
    dac_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .count   (count_r),
      .wr_en   (wr_en),
      .wr_addr (pend_addr_r),
      .probe_i (chain[i]),
      .probe_o (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      flag_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      flag_r  <= flag_nxt;
      if (load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= in_tuser;
      pend_addr_r <= in_tdata;
      hit_r       <= 1'b0;
    end else if (state_r == ST_SEARCH && chain[MAX_DEVICES].vld) begin
      hit_r <= chain[MAX_DEVICES].hit;
    end
    if (load_out) begin
      out_data_r <= {7'd0, flag_nxt, cnt_ext[OUT_CNT_W-1:0], is_new};
    end
  end

  assign cnt_ext = {{OUT_CNT_W{1'b0}}, count_nxt};

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    flag_nxt  = flag_r;
    wr_en     = 1'b0;
    load_out  = 1'b0;
    is_new    = 1'b0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = (in_tuser == CMD_CLEAR) ? ST_DONE : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (chain[MAX_DEVICES].vld) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
          if (cmd_r == CMD_CLEAR) begin
            count_nxt = '0;
            flag_nxt  = 1'b0;
          end else if (!hit_r) begin
            if (count_r >= CNT_W'(MAX_DEVICES)) begin
              if (!flag_r) begin
                flag_nxt = 1'b1;
                is_new   = 1'b1;
              end
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + 1'b1;
              is_new    = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_DEVICES))
    else $error("count beyond table depth");

  a_flag_full: assert property (@(posedge clk) disable iff (!rst_n)
    flag_r |-> (count_r == CNT_W'(MAX_DEVICES)))
    else $error("saturated flag set with table not full");

  a_probe_search: assert property (@(posedge clk) disable iff (!rst_n)
    chain[MAX_DEVICES].vld |-> (state_r == ST_SEARCH))
    else $error("probe left the row outside a search");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (count_r == $past(count_r) + 1'b1))
    else $error("table write without count advance");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import dac_pkg::*;

  localparam int MAX_DEV      = 64;
  localparam int RANDOM_ITEMS = 1800;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = MAX_DEV + 16;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] addr;
  } addr_item_t;

  typedef struct packed {
    logic                 overflowed;
    logic [OUT_CNT_W-1:0] distinct_count;
    logic                 is_new;
  } count_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // device_address[47:0]
  logic        in_tuser = 1'b0; // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // is_new, distinct_count[6:0], overflowed, zero pad

  distinct_address_counter #(.MAX_DEVICES(MAX_DEV)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  addr_item_t        pending_items[$];
  count_result_t     awaited_counts[$];
  logic [ADDR_W-1:0] seen_addr[MAX_DEV];
  int                stored_count = 0;
  bit                table_full = 1'b0;
  int                mismatches = 0;
  int                in_gap = 0;
  int                out_gap = 0;
  int                quiet_cycles = 0;
  bit                quiet_tail = 1'b0;

  function automatic count_result_t count_address(logic cmd, logic [ADDR_W-1:0] addr);
    count_result_t r;
    bit            hit;
    r = '0;
    hit = 1'b0;
    if (cmd == CMD_CLEAR) begin
      stored_count = 0;
      table_full = 1'b0;
    end else begin
      for (int i = 0; i < stored_count; i++)
        if (seen_addr[i] == addr) hit = 1'b1;
      if (!hit) begin
        if (stored_count >= MAX_DEV) begin
          if (!table_full) begin
            table_full = 1'b1;
            r.is_new = 1'b1;
          end
        end else begin
          seen_addr[stored_count] = addr;
          stored_count++;
          r.is_new = 1'b1;
        end
      end
    end
    r.distinct_count = stored_count[OUT_CNT_W-1:0];
    r.overflowed = table_full;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0: v = '0;
      1: v = '1;
      default: ;
    endcase
    return v[ADDR_W-1:0];
  endfunction

  task automatic add_item(logic cmd, logic [ADDR_W-1:0] addr);
    addr_item_t it;
    it.cmd = cmd;
    it.addr = addr;
    pending_items.push_back(it);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        awaited_counts.push_back(count_address(in_tuser, in_tdata));
      quiet_tail <= (pending_items.size() < 150);
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
          in_gap = $urandom_range(0, 2);
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tuser  <= pending_items[0].cmd;
          in_tdata  <= pending_items[0].addr;
          void'(pending_items.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    count_result_t got;
    count_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[8:0];
        if (awaited_counts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: is_new %0d count %0d overflowed %0d",
                     got.is_new, got.distinct_count, got.overflowed);
        end else begin
          want = awaited_counts.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected is_new %0d count %0d overflowed %0d, got %0d %0d %0d",
                       want.is_new, want.distinct_count, want.overflowed,
                       got.is_new, got.distinct_count, got.overflowed);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_gap = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0] pool[$];
    logic [ADDR_W-1:0] a;
    int                pool_n;
    int                run_len;
    int                total;
    int                pick;

    add_item(CMD_CLEAR, '1);
    add_item(CMD_OBSERVE, '0);
    add_item(CMD_OBSERVE, '1);
    add_item(CMD_OBSERVE, '0);
    add_item(CMD_OBSERVE, '1);
    add_item(CMD_OBSERVE, 48'hAAAA_AAAA_AAAA);
    add_item(CMD_OBSERVE, 48'h5555_5555_5555);
    add_item(CMD_OBSERVE, 48'h0000_0000_0001);
    add_item(CMD_OBSERVE, 48'h8000_0000_0000);
    add_item(CMD_OBSERVE, 48'hAAAA_AAAA_AAAA);
    add_item(CMD_OBSERVE, 48'hFFFF_FFFF_FFFE);
    add_item(CMD_CLEAR, 48'h1234_5678_9ABC);
    add_item(CMD_OBSERVE, '1);
    add_item(CMD_OBSERVE, '1);
    add_item(CMD_OBSERVE, 48'h7FFF_FFFF_FFFF);
    add_item(CMD_CLEAR, '0);
    add_item(CMD_CLEAR, '1);
    add_item(CMD_OBSERVE, 48'h0000_0000_0000);

    total = pending_items.size() + RANDOM_ITEMS;
    while (pending_items.size() < total) begin
      pool.delete();
      if ($urandom_range(0, 3) == 0) begin
        pool_n = $urandom_range(1, 16);
        run_len = $urandom_range(5, 40);
      end else begin
        pool_n = $urandom_range(60, 100);
        run_len = $urandom_range(80, 220);
      end
      for (int k = 0; k < pool_n; k++) begin
        if (k > 0 && $urandom_range(0, 3) == 0)
          a = pool[$urandom_range(0, k - 1)] ^ (48'h1 << $urandom_range(0, ADDR_W - 1));
        else
          a = rand_addr();
        pool.push_back(a);
      end
      for (int n = 0; n < run_len; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2)
          add_item(CMD_CLEAR, rand_addr());
        else if (pick < 8)
          add_item(CMD_OBSERVE, rand_addr());
        else
          add_item(CMD_OBSERVE, pool[$urandom_range(0, pool_n - 1)]);
      end
      add_item(CMD_CLEAR, rand_addr());
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_tvalid || awaited_counts.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_counts.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
